@@ src/rrs_pkg.sv @@
package rrs_pkg;

    // Request codes as they arrive on the command field.
    typedef enum logic [2:0] {
        CMD_WRITE      = 3'd0,
        CMD_READ       = 3'd1,
        CMD_MCAST      = 3'd2,
        CMD_RESET      = 3'd3,
        CMD_SYNC_BEGIN = 3'd4,
        CMD_SYNC_END   = 3'd5,
        CMD_DELETE     = 3'd6
    } t_cmd;

    // Sequencer control states.
    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    // Lookup token that walks the row of key cells, one cell per cycle.
    typedef struct packed {
        logic active;
        logic found;
        logic free_seen;
        logic del;
    } t_probe;

    localparam int MASK_BITS = 3;
    localparam int SEQ_BITS  = 32;

endpackage

@@ src/rrs_cell.sv @@
module rrs_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rrs_pkg::t_probe       i_probe,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic                  i_commit_ins,
    input  logic                  i_clear,
    output rrs_pkg::t_probe       o_probe
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic                r_claim;
    rrs_pkg::t_probe     r_probe;
    rrs_pkg::t_probe     n_probe;
    logic                hit;

    // Compare this cell's entry while the token sits at its input.
    assign hit = i_probe.active && r_valid && (r_key == i_key);

    always_comb begin
        n_probe           = i_probe;
        n_probe.found     = i_probe.found | hit;
        n_probe.free_seen = i_probe.free_seen | (i_probe.active & ~r_valid);
    end

    // Token register hands the lookup to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    // The first free cell that the token passes claims the pending insert.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_claim <= 1'b0;
        end else if (i_probe.active) begin
            r_claim <= ~r_valid & ~i_probe.free_seen;
        end
    end

    // Entry valid bit: clear, insert on commit, or drop on a delete hit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_commit_ins && r_claim) begin
            r_valid <= 1'b1;
        end else if (hit && i_probe.del) begin
            r_valid <= 1'b0;
        end
    end

    // Entry key is written only when the insert commits here.
    always_ff @(posedge i_clk) begin
        if (i_commit_ins && r_claim) begin
            r_key <= i_key;
        end
    end

    assign o_probe = r_probe;

endmodule

@@ src/replicated_read_sequencer.sv @@
// Replicated read sequencer.
// Input channel (i_in_valid / o_in_ready) takes one classified request word:
// command, key and sync stamp. Output channel (o_out_valid / i_out_ready)
// returns exactly one result word per request: replica mask, sequence
// number, stamped, read-one and insert-failed flags.
// Dirty keys live in a row of SET_ENTRIES cells. Write, read and delete
// requests send a lookup token down that row, one cell per cycle, and the
// next request is taken only after the token has left the last cell and
// the result is registered. All other requests act on the counters
// directly and return their result in the cycle after acceptance, so
// they can be taken every cycle while the receiver keeps up.
// A new request is taken only while the output register is empty or being
// drained in the same cycle; a stalled receiver holds the result word and
// blocks further requests. Synchronous reset empties the output register,
// clears every dirty entry and zeroes the counter, the round-robin pointer
// and both sync points. The reset request does the same to the state.
module replicated_read_sequencer #(
    parameter int KEY_BITS    = 64,
    parameter int SET_ENTRIES = 64,
    parameter int REPLICAS    = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_command,
    input  logic [63:0]                       i_key,
    input  logic [31:0]                       i_sync_stamp,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rrs_pkg::MASK_BITS-1:0]     o_replica_mask,
    output logic [rrs_pkg::SEQ_BITS-1:0]      o_seq_number,
    output logic                              o_stamped,
    output logic                              o_read_one,
    output logic                              o_insert_failed
);

    localparam int RW = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;

    rrs_pkg::t_state r_state, n_state;
    rrs_pkg::t_cmd   r_cmd;
    rrs_pkg::t_cmd   in_cmd;
    rrs_pkg::t_cmd   d_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic            r_inject;
    logic            accept;
    logic            in_search;
    logic            fin;
    logic            done;
    logic            clear;
    logic            commit_ins;
    logic            in_ready;

    logic [rrs_pkg::SEQ_BITS-1:0] r_seq_count, n_seq_count;
    logic [rrs_pkg::SEQ_BITS-1:0] r_started, n_started;
    logic [rrs_pkg::SEQ_BITS-1:0] r_finished, n_finished;
    logic [RW-1:0]                r_next_rep, n_next_rep;

    logic                           r_out_valid;
    logic [rrs_pkg::MASK_BITS-1:0]  r_mask, res_mask;
    logic [rrs_pkg::SEQ_BITS-1:0]   r_seq, res_seq;
    logic                           r_stamped, res_stamped;
    logic                           r_rone, res_rone;
    logic                           r_fail, res_fail;
    logic [rrs_pkg::MASK_BITS-1:0]  all_mask, rd_mask;

    rrs_pkg::t_probe w_probe [SET_ENTRIES+1];
    rrs_pkg::t_probe last;

    assign in_cmd = rrs_pkg::t_cmd'(i_command);
    assign accept = i_in_valid & in_ready;
    assign last   = w_probe[SET_ENTRIES];

    // Requests that need a lookup in the dirty set.
    always_comb begin
        case (in_cmd) inside
            rrs_pkg::CMD_WRITE, rrs_pkg::CMD_READ, rrs_pkg::CMD_DELETE: in_search = 1'b1;
            default: in_search = 1'b0;
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrs_pkg::ST_IDLE: begin
                if (accept && in_search) begin
                    n_state = rrs_pkg::ST_SEARCH;
                end
            end
            rrs_pkg::ST_SEARCH: begin
                if (last.active) begin
                    n_state = rrs_pkg::ST_IDLE;
                end
            end
            default: n_state = rrs_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        in_ready = 1'b0;
        fin      = 1'b0;
        unique case (r_state)
            rrs_pkg::ST_IDLE: begin
                in_ready = ~r_out_valid | i_out_ready;
            end
            rrs_pkg::ST_SEARCH: begin
                fin = last.active;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrs_pkg::ST_IDLE;
            r_inject <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= accept & in_search;
        end
    end

    // Request capture for the lookup pass.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= in_cmd;
            r_key <= i_key[KEY_BITS-1:0];
        end
    end

    // Row of key cells; the token enters in the cycle after acceptance.
    assign w_probe[0] = '{active: r_inject, found: 1'b0, free_seen: 1'b0,
                          del: (r_cmd == rrs_pkg::CMD_DELETE)};

    genvar g;
    generate
        for (g = 0; g < SET_ENTRIES; g++) begin : g_cell
            rrs_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_probe      (w_probe[g]),
                .i_key        (r_key),
                .i_commit_ins (commit_ins),
                .i_clear      (clear),
                .o_probe      (w_probe[g+1])
            );
        end
    endgenerate

    // Replica masks for writes, multicast and dirty reads, and for the round-robin single read.
    always_comb begin
        for (int b = 0; b < rrs_pkg::MASK_BITS; b++) begin
            all_mask[b] = (b < REPLICAS);
            rd_mask[b]  = (32'(r_next_rep) == 32'(b));
        end
    end

    assign done       = fin | (accept & ~in_search);
    assign d_cmd      = fin ? r_cmd : in_cmd;
    assign commit_ins = fin && (r_cmd == rrs_pkg::CMD_WRITE) && !last.found && last.free_seen;

    // Result word and state update of the finishing request.
    always_comb begin
        n_seq_count = r_seq_count;
        n_started   = r_started;
        n_finished  = r_finished;
        n_next_rep  = r_next_rep;
        res_mask    = '0;
        res_seq     = '0;
        res_stamped = 1'b0;
        res_rone    = 1'b0;
        res_fail    = 1'b0;
        clear       = 1'b0;
        if (done) begin
            case (d_cmd)
                rrs_pkg::CMD_WRITE: begin
                    n_seq_count = r_seq_count + 1'b1;
                    res_seq     = n_seq_count;
                    res_stamped = 1'b1;
                    res_mask    = all_mask;
                    res_fail    = ~last.found & ~last.free_seen;
                end
                rrs_pkg::CMD_READ: begin
                    if (!last.found) begin
                        res_mask   = rd_mask;
                        res_rone   = 1'b1;
                        n_next_rep = (r_next_rep == RW'(REPLICAS - 1)) ? '0
                                                                       : r_next_rep + 1'b1;
                    end else begin
                        n_seq_count = r_seq_count + 1'b1;
                        res_seq     = n_seq_count;
                        res_stamped = 1'b1;
                        res_mask    = all_mask;
                    end
                end
                rrs_pkg::CMD_MCAST: begin
                    n_seq_count = r_seq_count + 1'b1;
                    res_seq     = n_seq_count;
                    res_stamped = 1'b1;
                    res_mask    = all_mask;
                end
                rrs_pkg::CMD_RESET: begin
                    n_seq_count = '0;
                    n_started   = '0;
                    n_finished  = '0;
                    n_next_rep  = '0;
                    clear       = 1'b1;
                end
                rrs_pkg::CMD_SYNC_BEGIN: begin
                    res_seq     = r_seq_count;
                    res_stamped = 1'b1;
                    n_started   = r_seq_count;
                end
                rrs_pkg::CMD_SYNC_END: begin
                    if (i_sync_stamp == r_started && i_sync_stamp != r_finished) begin
                        clear      = 1'b1;
                        n_finished = r_started;
                        n_started  = '0;
                    end
                end
                default: begin
                    clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_count <= '0;
            r_started   <= '0;
            r_finished  <= '0;
            r_next_rep  <= '0;
        end else begin
            r_seq_count <= n_seq_count;
            r_started   <= n_started;
            r_finished  <= n_finished;
            r_next_rep  <= n_next_rep;
        end
    end

    // Output register holds the result word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_mask    <= res_mask;
            r_seq     <= res_seq;
            r_stamped <= res_stamped;
            r_rone    <= res_rone;
            r_fail    <= res_fail;
        end
    end

    assign o_in_ready      = in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_replica_mask  = r_mask;
    assign o_seq_number    = r_seq;
    assign o_stamped       = r_stamped;
    assign o_read_one      = r_rone;
    assign o_insert_failed = r_fail;

endmodule

@@ src/rrs_checker.sv @@
module rrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_replica_mask,
    input logic [31:0] o_seq_number,
    input logic        o_stamped,
    input logic        o_read_one,
    input logic        o_insert_failed
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // A stalled result word stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_seq_number)
            && $stable(o_replica_mask))
        else $error("stalled result word changed");

    // Unstamped words carry a zero sequence number.
    a_unstamped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_stamped |-> o_seq_number == 32'd0)
        else $error("sequence number without stamp");

    // A single-replica read is unstamped and goes to at most one replica.
    a_read_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_one |-> !o_stamped && $onehot0(o_replica_mask)
            && !o_insert_failed)
        else $error("bad single-replica read word");

    // A failed insert still belongs to a stamped write.
    a_fail_stamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_insert_failed |-> o_stamped)
        else $error("insert failure on an unstamped word");

endmodule

bind replicated_read_sequencer rrs_checker u_rrs_checker (.*);
